[sv/apmpc_pkg.sv]
// Shared types, constants and path arithmetic for the max-path closure block
`default_nettype none
package apmpc_pkg;

	localparam int NODES  = 64;
	localparam int NODE_W = $clog2(NODES);
	localparam int ADDR_W = 2 * NODE_W;

	localparam logic signed [31:0] NO_PATH  = 32'sh8000_0000;
	localparam logic signed [31:0] MAX_PATH = 32'sh7FFF_FFFF;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_CLOSE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CL_PAIR,
		ST_CL_SELF,
		ST_CL_UPD
	} state_e;

	typedef enum logic [1:0] {
		AD_IN,
		AD_IK,
		AD_IJ
	} addr_sel_e;

	typedef enum logic [1:0] {
		OUT_NONE,
		OUT_ZERO,
		OUT_READ
	} out_kind_e;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [31:0] weight;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               was_read;
	} rsp_t;

	typedef struct packed {
		logic              acc_write;
		logic              acc_read;
		logic              rd_a;
		logic              rd_b;
		addr_sel_e         addr_sel;
		logic              step_sum;
		logic              step_upd;
		out_kind_e         out_kind;
		logic [NODE_W-1:0] k;
		logic [NODE_W-1:0] i;
		logic [NODE_W-1:0] j;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

	function automatic logic signed [31:0] path_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		logic signed [31:0] r;
		s = {a[31], a} + {b[31], b};
		if (a == NO_PATH || b == NO_PATH) begin
			r = NO_PATH;
		end else if (s[32:31] == 2'b01) begin
			r = MAX_PATH;
		end else if (s[32:31] == 2'b10) begin
			r = NO_PATH;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/apmpc_ctrl.sv]
// Controller: opcode dispatch and closure sequencing over k, i, j
`default_nettype none
module apmpc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	input  wire logic [1:0]          opcode,
	input  wire apmpc_pkg::stat_t    stat,
	output logic                     req_ready,
	output apmpc_pkg::cmd_t          cmd
);

	localparam logic [apmpc_pkg::NODE_W-1:0] LAST = apmpc_pkg::NODE_W'(apmpc_pkg::NODES - 1);

	apmpc_pkg::state_e state_q, state_d;
	logic [apmpc_pkg::NODE_W-1:0] k_q, i_q, j_q, k_d, i_d, j_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apmpc_pkg::ST_IDLE;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			i_q     <= i_d;
			j_q     <= j_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		i_d          = i_q;
		j_d          = j_q;
		req_ready    = 1'b0;
		cmd          = '0;
		cmd.addr_sel = apmpc_pkg::AD_IN;
		cmd.out_kind = apmpc_pkg::OUT_NONE;
		cmd.k        = k_q;
		cmd.i        = i_q;
		cmd.j        = j_q;
		unique case (state_q)
			apmpc_pkg::ST_IDLE: begin
				req_ready = stat.out_free;
				if (req_valid && stat.out_free) begin
					unique case (opcode)
						apmpc_pkg::OP_WRITE: begin
							cmd.acc_write = 1'b1;
							cmd.out_kind  = apmpc_pkg::OUT_ZERO;
						end
						apmpc_pkg::OP_CLOSE: begin
							k_d     = '0;
							i_d     = '0;
							j_d     = '0;
							state_d = apmpc_pkg::ST_CL_PAIR;
						end
						apmpc_pkg::OP_READ: begin
							cmd.acc_read = 1'b1;
							cmd.rd_a     = 1'b1;
							state_d      = apmpc_pkg::ST_READ;
						end
						apmpc_pkg::OP_NONE: begin
							cmd.out_kind = apmpc_pkg::OUT_ZERO;
						end
					endcase
				end
			end
			apmpc_pkg::ST_READ: begin
				cmd.out_kind = apmpc_pkg::OUT_READ;
				state_d      = apmpc_pkg::ST_IDLE;
			end
			apmpc_pkg::ST_CL_PAIR: begin
				cmd.rd_a     = 1'b1;
				cmd.rd_b     = 1'b1;
				cmd.addr_sel = apmpc_pkg::AD_IK;
				state_d      = apmpc_pkg::ST_CL_SELF;
			end
			apmpc_pkg::ST_CL_SELF: begin
				cmd.rd_a     = 1'b1;
				cmd.addr_sel = apmpc_pkg::AD_IJ;
				cmd.step_sum = 1'b1;
				state_d      = apmpc_pkg::ST_CL_UPD;
			end
			apmpc_pkg::ST_CL_UPD: begin
				cmd.step_upd = 1'b1;
				cmd.addr_sel = apmpc_pkg::AD_IJ;
				state_d      = apmpc_pkg::ST_CL_PAIR;
				j_d          = j_q + 1'b1;
				if (j_q == LAST) begin
					i_d = i_q + 1'b1;
					if (i_q == LAST) begin
						k_d = k_q + 1'b1;
						if (k_q == LAST) begin
							cmd.out_kind = apmpc_pkg::OUT_ZERO;
							state_d      = apmpc_pkg::ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = apmpc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[sv/apmpc_dp.sv]
// Datapath: path matrix memory, saturating path adder, compare and result register
`default_nettype none
module apmpc_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire apmpc_pkg::req_t  req,
	input  wire apmpc_pkg::cmd_t  cmd,
	input  wire logic             rsp_ready,
	output apmpc_pkg::stat_t      stat,
	output logic                  rsp_valid,
	output apmpc_pkg::rsp_t       rsp
);

	localparam int DEPTH = apmpc_pkg::NODES * apmpc_pkg::NODES;

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rd_a_q, rd_b_q, cand_q;
	logic               rd_ok_q;
	logic               rsp_valid_q;
	apmpc_pkg::rsp_t    rsp_q;

	logic                         in_range;
	logic [apmpc_pkg::ADDR_W-1:0] in_addr, addr_a, addr_b, waddr;
	logic signed [31:0]           wdata;
	logic                         we;

	assign in_range = (int'(req.row) < apmpc_pkg::NODES) && (int'(req.col) < apmpc_pkg::NODES);
	assign in_addr  = {apmpc_pkg::NODE_W'(req.row), apmpc_pkg::NODE_W'(req.col)};
	assign addr_b   = {cmd.k, cmd.j};

	always_comb begin
		unique case (cmd.addr_sel)
			apmpc_pkg::AD_IK: addr_a = {cmd.i, cmd.k};
			apmpc_pkg::AD_IJ: addr_a = {cmd.i, cmd.j};
			default:          addr_a = in_addr;
		endcase
	end

	always_comb begin
		if (cmd.step_upd) begin
			we    = (rd_a_q < cand_q);
			waddr = {cmd.i, cmd.j};
			wdata = cand_q;
		end else begin
			we    = cmd.acc_write && in_range;
			waddr = in_addr;
			wdata = req.weight;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_a) begin
			rd_a_q <= mem[addr_a];
		end
		if (cmd.rd_b) begin
			rd_b_q <= mem[addr_b];
		end
	end

	// hold candidate sum of (i,k) and (k,j) for the compare step, and the range flag of a read
	always_ff @(posedge clk) begin
		if (cmd.step_sum) begin
			cand_q <= apmpc_pkg::path_add(rd_a_q, rd_b_q);
		end
		if (cmd.acc_read) begin
			rd_ok_q <= in_range;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.out_kind)
			apmpc_pkg::OUT_READ: begin
				rsp_q.value    <= rd_ok_q ? rd_a_q : '0;
				rsp_q.was_read <= 1'b1;
			end
			apmpc_pkg::OUT_ZERO: begin
				rsp_q.value    <= '0;
				rsp_q.was_read <= 1'b0;
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_kind != apmpc_pkg::OUT_NONE) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule
`default_nettype wire

[sv/all_pairs_max_path_closure.sv]
// Top level of the all-pairs max-path closure block
// Usage:
//   The req channel takes one word per command: write one matrix entry, run the
//   max-plus closure over the whole matrix, or read one entry. The rsp channel
//   returns exactly one word per command: the entry read (was_read set), or zero.
//   Weights are signed Q15.16; the most negative code means no path.
//   A write answers in the cycle after acceptance, a read after the registered
//   memory read and the rsp register. A closure updates every (i,j) for every k
//   in states ST_CL_PAIR, ST_CL_SELF and ST_CL_UPD: read (i,k) and (k,j) on the
//   two memory read ports, read (i,j) while the saturating sum registers, then
//   compare and write back. One write per cycle is taken while the rsp register
//   is free or drained; no new word is taken while a read or closure is in flight.
//   Reset clears the controller and the rsp valid flag; the matrix is not cleared
//   and an entry must be written before it is read or used by a closure.
//   When the receiver stalls, the finished word holds in the rsp register; the
//   next req word is taken as soon as that register is free or being drained.
`default_nettype none
module all_pairs_max_path_closure (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire apmpc_pkg::req_t  req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output apmpc_pkg::rsp_t       rsp
);

	apmpc_pkg::cmd_t  cmd;
	apmpc_pkg::stat_t stat;

	apmpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.opcode    (req.opcode),
		.stat      (stat),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	apmpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_kind != apmpc_pkg::OUT_NONE) |-> stat.out_free)
		else $error("rsp register loaded while occupied");

	a_no_accept_in_closure: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step_upd || cmd.step_sum) |-> !req_ready)
		else $error("req ready during closure");

	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req.opcode == apmpc_pkg::OP_READ)
		|=> (cmd.out_kind == apmpc_pkg::OUT_READ))
		else $error("read not answered on following cycle");

	a_single_port_use: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_upd |-> (!cmd.acc_write && !cmd.rd_a && !cmd.rd_b))
		else $error("memory access overlaps closure update");

endmodule
`default_nettype wire

[verif/apmpc_checker.sv]
// Checker for the max-path closure block: shadow matrix, reply prediction and reply compare
module apmpc_checker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire logic            req_ready,
	input  wire apmpc_pkg::req_t req,
	input  wire logic            rsp_valid,
	input  wire logic            rsp_ready,
	input  wire apmpc_pkg::rsp_t rsp,
	output int                   mismatches,
	output int                   owed_count
);

	localparam int N = apmpc_pkg::NODES;

	logic signed [31:0] shadow_paths [N*N];
	apmpc_pkg::rsp_t    owed_replies [$];

	initial begin
		mismatches = 0;
		owed_count = 0;
	end

	task automatic flag_mismatch(input string msg);
		if (mismatches < 200) begin
			$display("%0t: %s", $time, msg);
		end
		mismatches++;
	endtask

	function automatic logic signed [31:0] sat_path_sum(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint s;
		if (a == apmpc_pkg::NO_PATH || b == apmpc_pkg::NO_PATH) begin
			return apmpc_pkg::NO_PATH;
		end
		s = longint'(a) + longint'(b);
		if (s > longint'(apmpc_pkg::MAX_PATH)) begin
			return apmpc_pkg::MAX_PATH;
		end
		if (s < longint'(apmpc_pkg::NO_PATH)) begin
			return apmpc_pkg::NO_PATH;
		end
		return s[31:0];
	endfunction

	function automatic void close_paths();
		logic signed [31:0] cand;
		for (int k = 0; k < N; k++) begin
			for (int i = 0; i < N; i++) begin
				for (int j = 0; j < N; j++) begin
					cand = sat_path_sum(shadow_paths[i*N+k], shadow_paths[k*N+j]);
					if (shadow_paths[i*N+j] < cand) begin
						shadow_paths[i*N+j] = cand;
					end
				end
			end
		end
	endfunction

	function automatic apmpc_pkg::rsp_t predict_reply(input apmpc_pkg::req_t w);
		apmpc_pkg::rsp_t r;
		logic in_range;
		r = '0;
		in_range = (int'(w.row) < N) && (int'(w.col) < N);
		case (apmpc_pkg::op_e'(w.opcode))
			apmpc_pkg::OP_WRITE: begin
				if (in_range) begin
					shadow_paths[int'(w.row)*N + int'(w.col)] = w.weight;
				end
			end
			apmpc_pkg::OP_CLOSE: begin
				close_paths();
			end
			apmpc_pkg::OP_READ: begin
				r.was_read = 1'b1;
				if (in_range) begin
					r.value = shadow_paths[int'(w.row)*N + int'(w.col)];
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : watch
		apmpc_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (owed_replies.size() == 0) begin
					flag_mismatch($sformatf("reply word with nothing owed: value %h was_read %b",
						rsp.value, rsp.was_read));
				end else begin
					want = owed_replies.pop_front();
					if (rsp.value !== want.value) begin
						flag_mismatch($sformatf("value %h, expected %h", rsp.value, want.value));
					end
					if (rsp.was_read !== want.was_read) begin
						flag_mismatch($sformatf("was_read %b, expected %b",
							rsp.was_read, want.was_read));
					end
				end
			end
			if (req_valid && req_ready) begin
				owed_replies.push_back(predict_reply(req));
			end
			owed_count = owed_replies.size();
		end
	end

endmodule

[verif/tb_all_pairs_max_path_closure.sv]
// Testbench top for the max-path closure block: stimulus, flow control and verdict
module tb_all_pairs_max_path_closure;

	localparam int CYCLE_LIMIT = 6_000_000;

	logic            clk;
	logic            arst_n    = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_ready;
	apmpc_pkg::req_t req       = '0;
	logic            rsp_valid;
	logic            rsp_ready = 1'b0;
	apmpc_pkg::rsp_t rsp;

	int mismatches;
	int owed_count;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int cycle_count   = 0;
	logic [5:0] last_row = '0;
	logic [5:0] last_col = '0;

	all_pairs_max_path_closure dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	apmpc_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.mismatches (mismatches),
		.owed_count (owed_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_all_pairs_max_path_closure: done, errors");
			$finish;
		end
	end

	task automatic send_word(input apmpc_pkg::req_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(negedge clk);
		while (!req_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	task automatic put(input apmpc_pkg::op_e op, input logic [5:0] r, input logic [5:0] c,
			input logic signed [31:0] wt);
		apmpc_pkg::req_t w;
		w.opcode = op;
		w.row    = r;
		w.col    = c;
		w.weight = wt;
		send_word(w);
	endtask

	function automatic logic signed [31:0] pick_weight();
		logic signed [31:0] wt;
		case ($urandom_range(9))
			0, 1:    wt = apmpc_pkg::NO_PATH;
			2:       wt = apmpc_pkg::MAX_PATH;
			3:       wt = ($urandom_range(1)) ? 32'sh8000_0001 : -32'sd1;
			4, 5, 6: wt = $urandom;
			default: wt = int'($urandom_range(1 << 21)) - (1 << 20);
		endcase
		return wt;
	endfunction

	task automatic run_phase(input int items, input int idle_pct, input int stall_pct,
			input int close_at);
		apmpc_pkg::req_t w;
		int pick;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		for (int n = 0; n < items; n++) begin
			w.row    = 6'($urandom);
			w.col    = 6'($urandom);
			w.weight = pick_weight();
			pick     = $urandom_range(99);
			if (n == close_at) begin
				w.opcode = apmpc_pkg::OP_CLOSE;
			end else if (pick < 45) begin
				w.opcode = apmpc_pkg::OP_WRITE;
				last_row = w.row;
				last_col = w.col;
			end else if (pick < 92) begin
				w.opcode = apmpc_pkg::OP_READ;
				if ($urandom_range(1)) begin
					w.row = last_row;
					w.col = last_col;
				end
			end else begin
				w.opcode = apmpc_pkg::OP_NONE;
			end
			send_word(w);
		end
	endtask

	initial begin
		logic signed [31:0] wt;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every entry with weights that keep the graph free of positive cycles
		for (int r = 0; r < apmpc_pkg::NODES; r++) begin
			for (int c = 0; c < apmpc_pkg::NODES; c++) begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5, 6, 7, 8: wt = apmpc_pkg::NO_PATH;
					9:       wt = 32'sd0;
					default: wt = -int'($urandom_range(1 << 20, 1));
				endcase
				put(apmpc_pkg::OP_WRITE, r[5:0], c[5:0], wt);
			end
		end
		put(apmpc_pkg::OP_CLOSE, 6'd0, 6'd0, 32'sd0);

		put(apmpc_pkg::OP_READ,  6'd0,  6'd0,  32'sd0);
		put(apmpc_pkg::OP_READ,  6'd63, 6'd63, 32'sd0);
		put(apmpc_pkg::OP_READ,  6'd0,  6'd63, 32'sd0);
		put(apmpc_pkg::OP_READ,  6'd63, 6'd0,  32'sd0);
		put(apmpc_pkg::OP_WRITE, 6'd0,  6'd0,  apmpc_pkg::MAX_PATH);
		put(apmpc_pkg::OP_READ,  6'd0,  6'd0,  32'sd0);
		put(apmpc_pkg::OP_WRITE, 6'd63, 6'd63, apmpc_pkg::NO_PATH);
		put(apmpc_pkg::OP_READ,  6'd63, 6'd63, 32'sd0);
		put(apmpc_pkg::OP_WRITE, 6'd0,  6'd63, 32'sh8000_0001);
		put(apmpc_pkg::OP_READ,  6'd0,  6'd63, 32'sd0);
		put(apmpc_pkg::OP_WRITE, 6'd63, 6'd0,  -32'sd1);
		put(apmpc_pkg::OP_READ,  6'd63, 6'd0,  32'sd0);
		put(apmpc_pkg::OP_WRITE, 6'd5,  6'd6,  32'sh7FFF_0000);
		put(apmpc_pkg::OP_WRITE, 6'd6,  6'd7,  32'sh7FFF_0000);
		put(apmpc_pkg::OP_WRITE, 6'd8,  6'd9,  32'sh8000_0001);
		put(apmpc_pkg::OP_WRITE, 6'd9,  6'd10, -32'sd5);
		put(apmpc_pkg::OP_WRITE, 6'd42, 6'd21, 32'sd0);
		put(apmpc_pkg::OP_READ,  6'd42, 6'd21, 32'sd0);
		put(apmpc_pkg::OP_NONE,  6'd63, 6'd63, -32'sd1);
		put(apmpc_pkg::OP_NONE,  6'd0,  6'd0,  32'sd0);

		run_phase(275, 0, 0, -1);
		run_phase(275, 60, 0, -1);
		run_phase(275, 0, 60, -1);
		run_phase(275, 6, 6, 137);

		req_valid <= 1'b0;
		@(negedge clk);
		while (owed_count != 0) begin
			@(negedge clk);
		end
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_all_pairs_max_path_closure: done, clean");
		end else begin
			$display("tb_all_pairs_max_path_closure: done, errors");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/apmpc_pkg.sv
sv/apmpc_ctrl.sv
sv/apmpc_dp.sv
sv/all_pairs_max_path_closure.sv
verif/apmpc_checker.sv
verif/tb_all_pairs_max_path_closure.sv
